FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: sv/tspfr_pkg.sv
package tspfr_pkg;

    localparam int PidEntries = 8192;
    localparam int NumOutputs = 16;
    localparam int PidW       = $clog2(PidEntries);
    localparam int QDepth     = 2;

    localparam logic [7:0]      SYNC_BYTE = 8'h47;
    localparam logic [PidW-1:0] PID_NULL  = 13'h1FFF;
    localparam logic [PidW-1:0] PID_PAT   = 13'h0000;
    localparam logic [PidW-1:0] PID_SDT   = 13'h0011;
    localparam logic [PidW-1:0] PID_EIT   = 13'h0012;

    localparam logic [1:0] REQ_HDR   = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ACT_BAD_SYNC = 3'd0,
        ACT_NULL     = 3'd1,
        ACT_PSI      = 3'd2,
        ACT_UNROUTED = 3'd3,
        ACT_FORWARD  = 3'd4,
        ACT_TABLE    = 3'd5
    } t_act;

    typedef enum logic [1:0] {
        OP_HDR    = 2'd0,
        OP_DIRECT = 2'd1,
        OP_WRITE  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } t_state;

    typedef struct packed {
        logic [3:0]      cc;
        logic            psi;
        logic            routed;
        logic [3:0]      oidx;
        logic [PidW-1:0] new_pid;
    } t_entry;

    typedef struct packed {
        t_op             op;
        t_act            act;
        logic [31:0]     hdr;
        logic [PidW-1:0] wpid;
        t_entry          went;
    } t_qitem;

    typedef struct packed {
        t_act        act;
        logic [31:0] hdr;
        logic [3:0]  idx;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic sweeping;
    } t_back_stat;

endpackage

FILE: sv/ts_pid_filter_remap_cc_unit.sv
// TS PID filter / remapper working on 4-byte transport stream headers.
// Slave stream: tuser carries the request type (header, write entry, clear
// table); tdata carries the header word and the table entry fields.
// Master stream: one transaction per known request, tuser = action code, tdata =
// rewritten header and output index (zero unless forwarded).
// Unknown request types are consumed silently.
// Headers with a bad sync byte, the null PID or a fixed PSI PID are resolved
// in the front decoder. Others read the 8192-entry route table (one read,
// one write port): a header is read from the table in the idle state and
// its result is registered in the exec state, where the back end takes no
// new request; direct results or entry writes retire one per cycle while
// the receiver is ready. A two-entry queue decouples decoder and table engine.
// Reset and each table clear sweep the table one entry per cycle; tready is
// low during the sweep. A clear's result is issued when the sweep starts,
// and later requests see the cleared table.
// A stalled receiver holds the result register; the queue keeps taking
// input until it fills, then tready drops.
`include "assert_macros.svh"

module ts_pid_filter_remap_cc_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] header_word, [44:32] entry_pid, [45] entry_routed,
    // [49:46] entry_output, [62:50] entry_new_pid, [63] entry_psi_tap
    input  logic [63:0] i_s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] out_header, [35:32] out_index, [39:36] zero
    output logic [39:0] o_m_axis_tdata,
    // [2:0] action
    output logic [2:0]  o_m_axis_tuser
);
    import tspfr_pkg::*;

    logic       q_push, q_pop;
    t_qitem     push_item, head_item;
    t_q_stat    q_stat;
    t_back_stat back_stat;
    t_result    result;

    tspfr_front u_front (
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_req       (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata),
        .i_q_stat    (q_stat),
        .i_back_stat (back_stat),
        .o_push      (q_push),
        .o_item      (push_item)
    );

    tspfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    tspfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (head_item),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_stat   (back_stat),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = {4'b0, result.idx, result.hdr};
    assign o_m_axis_tuser = result.act;

    `ASSERT_NEVER(a_no_accept_in_sweep, i_clk, i_rst_n, back_stat.sweeping && o_s_axis_tready, "input ready during table sweep")
    `ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, q_push && q_stat.full, "push into full queue")
    `ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, q_pop && q_stat.empty, "pop from empty queue")
    `ASSERT_CLK(a_drop_zero, i_clk, i_rst_n, (o_m_axis_tvalid && result.act != ACT_FORWARD) |-> (o_m_axis_tdata == '0), "non-forward result carries data")

endmodule

FILE: sv/tspfr_front.sv
module tspfr_front (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_req,
    input  logic [63:0]           i_data,
    input  tspfr_pkg::t_q_stat    i_q_stat,
    input  tspfr_pkg::t_back_stat i_back_stat,
    output logic                  o_push,
    output tspfr_pkg::t_qitem     o_item
);
    import tspfr_pkg::*;

    logic [31:0]     hdr;
    logic [PidW-1:0] pid;
    logic            known;

    assign hdr     = i_data[31:0];
    assign pid     = hdr[20:8];
    assign o_ready = !i_q_stat.full && !i_back_stat.sweeping;

    always_comb begin
        o_item              = '0;
        o_item.hdr          = hdr;
        o_item.wpid         = i_data[44:32];
        o_item.went.routed  = i_data[45];
        o_item.went.oidx    = i_data[49:46];
        o_item.went.new_pid = i_data[62:50];
        o_item.went.psi     = i_data[63];
        o_item.op           = OP_HDR;
        o_item.act          = ACT_BAD_SYNC;
        known               = 1'b1;
        unique case (i_req)
            REQ_HDR: begin
                if (hdr[31:24] != SYNC_BYTE) begin
                    o_item.op  = OP_DIRECT;
                    o_item.act = ACT_BAD_SYNC;
                end else if (pid == PID_NULL) begin
                    o_item.op  = OP_DIRECT;
                    o_item.act = ACT_NULL;
                end else if (pid == PID_PAT || pid == PID_SDT || pid == PID_EIT) begin
                    o_item.op  = OP_DIRECT;
                    o_item.act = ACT_PSI;
                end else begin
                    o_item.op  = OP_HDR;
                end
            end
            REQ_WRITE: begin
                o_item.op  = OP_WRITE;
                o_item.act = ACT_TABLE;
            end
            REQ_CLEAR: begin
                o_item.op  = OP_CLEAR;
                o_item.act = ACT_TABLE;
            end
            default: known = 1'b0;
        endcase
    end

    // unknown request types are consumed and produce nothing
    assign o_push = i_valid && o_ready && known;

endmodule

FILE: sv/tspfr_queue.sv
module tspfr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tspfr_pkg::t_qitem  i_item,
    input  logic               i_pop,
    output tspfr_pkg::t_qitem  o_item,
    output tspfr_pkg::t_q_stat o_stat
);
    import tspfr_pkg::*;

    localparam int PtrW = $clog2(QDepth);
    localparam int CntW = $clog2(QDepth + 1);

    t_qitem          r_buf [QDepth];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_cnt;

    assign o_item       = r_buf[r_rptr];
    assign o_stat.full  = (r_cnt == CntW'(QDepth));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PtrW'(QDepth - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PtrW'(QDepth - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_item;
        end
    end

endmodule

FILE: sv/tspfr_back.sv
module tspfr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tspfr_pkg::t_qitem     i_item,
    input  tspfr_pkg::t_q_stat    i_q_stat,
    output logic                  o_pop,
    output tspfr_pkg::t_back_stat o_stat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tspfr_pkg::t_result    o_result
);
    import tspfr_pkg::*;

    t_state          r_state, n_state;
    logic [PidW-1:0] r_addr, n_addr;
    logic [31:0]     r_hdr;
    t_entry          r_rd;
    t_entry          r_mem [PidEntries];

    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;

    logic            out_free;
    logic            mem_we, mem_re;
    logic [PidW-1:0] mem_waddr, mem_raddr;
    t_entry          mem_wdata;

    assign out_free        = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_result        = r_out;
    assign o_stat.sweeping = (r_state == ST_CLEAR);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_addr;
        mem_raddr   = i_item.hdr[20:8];
        mem_wdata   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                n_addr    = r_addr + 1'b1;
                if (r_addr == PidW'(PidEntries - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    unique case (i_item.op)
                        OP_HDR: begin
                            o_pop   = 1'b1;
                            mem_re  = 1'b1;
                            n_addr  = i_item.hdr[20:8];
                            n_state = ST_EXEC;
                        end
                        OP_DIRECT, OP_WRITE, OP_CLEAR: begin
                            if (out_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out.act   = i_item.act;
                                n_out.hdr   = '0;
                                n_out.idx   = '0;
                                if (i_item.op == OP_WRITE) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = i_item.wpid;
                                    mem_wdata = i_item.went;
                                end
                                if (i_item.op == OP_CLEAR) begin
                                    n_addr  = '0;
                                    n_state = ST_CLEAR;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.hdr   = '0;
                    n_out.idx   = '0;
                    n_state     = ST_IDLE;
                    if (r_rd.psi) begin
                        n_out.act = ACT_PSI;
                    end else if (!r_rd.routed || 9'(r_rd.oidx) >= 9'(NumOutputs)) begin
                        n_out.act = ACT_UNROUTED;
                    end else begin
                        n_out.act    = ACT_FORWARD;
                        n_out.hdr    = {r_hdr[31:21], r_rd.new_pid, r_hdr[7:4], r_rd.cc};
                        n_out.idx    = r_rd.oidx;
                        mem_we       = 1'b1;
                        mem_waddr    = r_addr;
                        mem_wdata    = r_rd;
                        mem_wdata.cc = r_rd.cc + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_pop) begin
            r_hdr <= i_item.hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

endmodule
